// ----- rtl/core/mtg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_pkg - shared types and constants for the melody tone generator
// Beat layouts, opcodes, register indexes, sequencer states and the sine ROM.
// ----------------------------------------------------------------------------
package mtg_pkg;

  // Opcodes carried in the op field of an input beat
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_LOAD   = 2'd2,
    OP_START  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_ADDR_W-1:0] CFG_MELODY_LENGTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_RATE   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FIFTY_HZ      = 2'd2;

  // Field widths
  localparam int LENGTH_W     = 7;
  localparam int RATE_W       = 18;
  localparam int ENTRY_IDX_W  = 6;
  localparam int ENTRY_SLOTS  = 2 ** ENTRY_IDX_W;
  localparam int FREQ_W       = 16;
  localparam int DUR_W        = 16;
  localparam int NOTE_WORD_W  = FREQ_W + DUR_W;
  localparam int SAMPLE_W     = 14;
  localparam int NOTE_INDEX_W = 6;

  // Phase accumulator and its serial adder
  localparam int PHASE_W      = 32;
  localparam int DIGIT_W      = 8;
  localparam int PHASE_DIGITS = PHASE_W / DIGIT_W;
  localparam int DIGIT_CNT_W  = $clog2(PHASE_DIGITS);

  // Note countdown and 50 Hz tick spreading
  localparam int TICKS_W      = 17;
  localparam int SPREAD_W     = 3;
  localparam int SPREAD_SUM_W = 4;
  localparam logic [SPREAD_SUM_W-1:0] SPREAD_ADD = 4'd6;
  localparam logic [SPREAD_SUM_W-1:0] SPREAD_DIV = 4'd5;

  // Sine ROM: 256 entries built from a quarter wave, amplitude 6000
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
  localparam int QUARTER_N    = SINE_ENTRIES / 4;
  localparam int QUARTER_W    = 13;

  localparam logic [QUARTER_W-1:0] QUARTER_WAVE [0:QUARTER_N] = '{
    13'd0,    13'd147,  13'd294,  13'd441,  13'd588,  13'd734,  13'd880,
    13'd1025, 13'd1170, 13'd1314, 13'd1457, 13'd1600, 13'd1741, 13'd1882,
    13'd2021, 13'd2159, 13'd2296, 13'd2431, 13'd2565, 13'd2697, 13'd2828,
    13'd2957, 13'd3084, 13'd3209, 13'd3333, 13'd3454, 13'd3574, 13'd3691,
    13'd3806, 13'd3919, 13'd4029, 13'd4137, 13'd4242, 13'd4345, 13'd4445,
    13'd4543, 13'd4638, 13'd4730, 13'd4819, 13'd4905, 13'd4988, 13'd5069,
    13'd5146, 13'd5220, 13'd5291, 13'd5359, 13'd5423, 13'd5485, 13'd5543,
    13'd5597, 13'd5649, 13'd5697, 13'd5741, 13'd5782, 13'd5820, 13'd5854,
    13'd5884, 13'd5911, 13'd5935, 13'd5954, 13'd5971, 13'd5983, 13'd5992,
    13'd5998, 13'd6000
  };

  // Input beat
  typedef struct packed {
    op_t                    op;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [FREQ_W-1:0]      entry_freq;
    logic [DUR_W-1:0]       entry_duration;
  } item_t;

  // Result beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [NOTE_INDEX_W-1:0]    note_index;
  } result_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_TICK,
    ST_MOD,
    ST_READ,
    ST_LOAD,
    ST_DIV
  } state_t;

  // Sine lookup: quadrant mirror and sign of the quarter wave
  function automatic logic signed [SAMPLE_W-1:0] sine_value(
    input logic [SINE_IDX_W-1:0] idx
  );
    logic [1:0]                 quad;
    logic [SINE_IDX_W-3:0]      pos;
    logic [SINE_IDX_W-2:0]      qi;
    logic signed [SAMPLE_W-1:0] mag;
    quad = idx[SINE_IDX_W-1 -: 2];
    pos  = idx[SINE_IDX_W-3:0];
    qi   = quad[0] ? (SINE_IDX_W-1)'(QUARTER_N - int'(pos)) : {1'b0, pos};
    mag  = signed'({1'b0, QUARTER_WAVE[qi]});
    return quad[1] ? -mag : mag;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mtg_serial_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_serial_div - bit-serial restoring divider
// One dividend bit per cycle, MSB first; done pulses together with the final
// quotient and remainder. A zero divisor gives an all-ones quotient.
// ----------------------------------------------------------------------------
module mtg_serial_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 18,
  parameter int Q_W   = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [Q_W-1:0]        quotient,
  output logic [DVS_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] count;
  logic             run;

  logic [DVS_W:0]   shifted;
  logic             fits;
  logic [DVS_W:0]   diff;

  // one restoring step: bring down a bit, subtract if it fits
  always_comb begin
    shifted = {remainder, dvd[DVD_W-1]};
    fits    = (shifted >= {1'b0, dvs});
    diff    = shifted - {1'b0, dvs};
  end

  // control: run flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        count <= CNT_W'(DVD_W);
      end else if (run) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
      quotient  <= '0;
    end else if (run) begin
      dvd       <= {dvd[DVD_W-2:0], 1'b0};
      remainder <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quotient  <= Q_W'({quotient, fits});
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/melody_tone_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// melody_tone_generator - melody sequencer with a DDS sine tone
// Note table of frequency/duration words, frame-tick countdown, serial
// phase-increment divider and a byte-serial phase accumulator.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | beat
//  --------+-----------+----------------------------+-----------------------
//  item    | in        | item_valid / item_stall    | mtg_pkg::item_t
//  result  | out       | result_valid / result_stall| mtg_pkg::result_t
//  cfg     | in        | cfg_we (no wait)           | cfg_addr, cfg_data
//
//  Sample beat: no further state during a rest, else the PHASE state adds
//  the step to the phase, 8 bits/cycle. Load beat: no further state. Start
//  beat: the READ, LOAD and DIV states follow (48 dividend bits).
//  Frame tick: the TICK state alone without a note change; a note change adds
//  the index wrap (MOD), the table read, the load and the divider; in 50 Hz
//  mode a frame may run this twice.
//  Reset is synchronous; the note table is not cleared. A waiting result
//  stalls the input side only while result_stall holds it.
// ----------------------------------------------------------------------------
module melody_tone_generator #(
  parameter int NOTE_DEPTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire mtg_pkg::item_t                      item,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output mtg_pkg::result_t                         result,
  input  wire logic                                cfg_we,
  input  wire logic [mtg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [mtg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NOTE_W = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
  localparam int CNT_W  = NOTE_W + 1;
  localparam int WIDE_W = (CNT_W > mtg_pkg::LENGTH_W) ? CNT_W : mtg_pkg::LENGTH_W;
  localparam int DIV_DVD_W = mtg_pkg::FREQ_W + mtg_pkg::PHASE_W;

  // configuration registers
  logic [mtg_pkg::LENGTH_W-1:0] melody_length;
  logic [mtg_pkg::RATE_W-1:0]   sample_rate;
  logic                         fifty_hz_mode;

  // player state
  mtg_pkg::state_t                state, state_next;
  logic [mtg_pkg::PHASE_W-1:0]    phase_accum;
  logic [mtg_pkg::PHASE_W-1:0]    phase_step;
  logic [NOTE_W-1:0]              current_note;
  logic [mtg_pkg::TICKS_W-1:0]    ticks_left;
  logic [mtg_pkg::SPREAD_W-1:0]   tick_spread;
  logic [1:0]                     pending;
  logic [mtg_pkg::DIGIT_CNT_W-1:0] digit;
  logic                           carry;

  // note table
  logic [mtg_pkg::NOTE_WORD_W-1:0] note_mem [NOTE_DEPTH];
  logic [mtg_pkg::NOTE_WORD_W-1:0] note_rd;
  logic [NOTE_W-1:0]               slot_wrap [mtg_pkg::ENTRY_SLOTS];

  // control
  logic                        item_fire;
  logic                        mod_start, mod_done, div_start, div_done;
  logic                        tick_down;
  logic [WIDE_W-1:0]           length_wide;
  logic [CNT_W-1:0]            note_len;
  logic [CNT_W-1:0]            mod_rem;
  logic [mtg_pkg::PHASE_W-1:0] div_quo;
  logic [mtg_pkg::RATE_W-1:0]  div_rem;
  logic [mtg_pkg::SPREAD_SUM_W-1:0] spread_sum;
  logic [mtg_pkg::DIGIT_W:0]   digit_sum;

  assign item_fire  = item_valid && !item_stall;
  assign item_stall = (state != mtg_pkg::ST_IDLE) || (result_valid && result_stall);

  // table slot wrap: entry_index modulo NOTE_DEPTH as a constant table
  for (genvar gi = 0; gi < mtg_pkg::ENTRY_SLOTS; gi++) begin : g_wrap
    assign slot_wrap[gi] = NOTE_W'(gi % NOTE_DEPTH);
  end

  // effective melody length, 1..NOTE_DEPTH
  always_comb begin
    if (melody_length == '0) begin
      length_wide = WIDE_W'(1);
    end else if (WIDE_W'(melody_length) > WIDE_W'(NOTE_DEPTH)) begin
      length_wide = WIDE_W'(NOTE_DEPTH);
    end else begin
      length_wide = WIDE_W'(melody_length);
    end
    note_len = CNT_W'(length_wide);
  end

  // 50 Hz spreading sum and one byte of the serial phase add
  assign spread_sum = {1'b0, tick_spread} + mtg_pkg::SPREAD_ADD;
  assign digit_sum  = {1'b0, phase_accum[mtg_pkg::DIGIT_W-1:0]}
                    + {1'b0, phase_step[mtg_pkg::DIGIT_W-1:0]}
                    + (mtg_pkg::DIGIT_W+1)'(carry);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      melody_length <= mtg_pkg::LENGTH_W'(1);
      sample_rate   <= mtg_pkg::RATE_W'(48000);
      fifty_hz_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mtg_pkg::CFG_MELODY_LENGTH: melody_length <= cfg_data[mtg_pkg::LENGTH_W-1:0];
        mtg_pkg::CFG_SAMPLE_RATE:   sample_rate   <= cfg_data[mtg_pkg::RATE_W-1:0];
        mtg_pkg::CFG_FIFTY_HZ:      fifty_hz_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mtg_pkg::ST_IDLE: begin
        if (item_fire) begin
          unique case (item.op)
            mtg_pkg::OP_SAMPLE:
              state_next = (phase_step != '0) ? mtg_pkg::ST_PHASE : mtg_pkg::ST_IDLE;
            mtg_pkg::OP_TICK:  state_next = mtg_pkg::ST_TICK;
            mtg_pkg::OP_LOAD:  state_next = mtg_pkg::ST_IDLE;
            mtg_pkg::OP_START: state_next = mtg_pkg::ST_READ;
          endcase
        end
      end
      mtg_pkg::ST_PHASE: begin
        if (digit == mtg_pkg::DIGIT_CNT_W'(mtg_pkg::PHASE_DIGITS - 1)) begin
          state_next = mtg_pkg::ST_IDLE;
        end
      end
      mtg_pkg::ST_TICK: begin
        if (ticks_left <= mtg_pkg::TICKS_W'(1)) begin
          state_next = mtg_pkg::ST_MOD;
        end else if (pending == 2'd1) begin
          state_next = mtg_pkg::ST_IDLE;
        end
      end
      mtg_pkg::ST_MOD: begin
        if (mod_done) state_next = mtg_pkg::ST_READ;
      end
      mtg_pkg::ST_READ: state_next = mtg_pkg::ST_LOAD;
      mtg_pkg::ST_LOAD: state_next = mtg_pkg::ST_DIV;
      mtg_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = (pending == 2'd2) ? mtg_pkg::ST_TICK : mtg_pkg::ST_IDLE;
        end
      end
      default: state_next = mtg_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mod_start = 1'b0;
    div_start = 1'b0;
    tick_down = 1'b0;
    unique case (state)
      mtg_pkg::ST_TICK: begin
        mod_start = (ticks_left <= mtg_pkg::TICKS_W'(1));
        tick_down = !mod_start;
      end
      mtg_pkg::ST_LOAD: div_start = 1'b1;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // player registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accum  <= '0;
      phase_step   <= '0;
      current_note <= '0;
      ticks_left   <= '0;
      tick_spread  <= '0;
      pending      <= '0;
      digit        <= '0;
      carry        <= 1'b0;
    end else begin
      unique case (state)
        mtg_pkg::ST_IDLE: begin
          digit <= '0;
          carry <= 1'b0;
          if (item_fire && item.op == mtg_pkg::OP_TICK) begin
            if (!fifty_hz_mode) begin
              pending <= 2'd1;
            end else if (spread_sum >= (mtg_pkg::SPREAD_DIV << 1)) begin
              pending     <= 2'd2;
              tick_spread <= mtg_pkg::SPREAD_W'(spread_sum - (mtg_pkg::SPREAD_DIV << 1));
            end else begin
              pending     <= 2'd1;
              tick_spread <= mtg_pkg::SPREAD_W'(spread_sum - mtg_pkg::SPREAD_DIV);
            end
          end else if (item_fire && item.op == mtg_pkg::OP_START) begin
            current_note <= '0;
            pending      <= 2'd1;
          end
        end
        mtg_pkg::ST_PHASE: begin
          // byte-serial add; both words rotate back into place once all four bytes are added
          phase_accum <= {digit_sum[mtg_pkg::DIGIT_W-1:0],
                          phase_accum[mtg_pkg::PHASE_W-1:mtg_pkg::DIGIT_W]};
          phase_step  <= {phase_step[mtg_pkg::DIGIT_W-1:0],
                          phase_step[mtg_pkg::PHASE_W-1:mtg_pkg::DIGIT_W]};
          carry       <= digit_sum[mtg_pkg::DIGIT_W];
          digit       <= digit + mtg_pkg::DIGIT_CNT_W'(1);
        end
        mtg_pkg::ST_TICK: begin
          if (tick_down) begin
            ticks_left <= ticks_left - mtg_pkg::TICKS_W'(1);
            pending    <= pending - 2'd1;
          end
        end
        mtg_pkg::ST_MOD: begin
          if (mod_done) current_note <= NOTE_W'(mod_rem);
        end
        mtg_pkg::ST_LOAD: begin
          ticks_left <= mtg_pkg::TICKS_W'(note_rd[mtg_pkg::DUR_W-1:0]);
        end
        mtg_pkg::ST_DIV: begin
          if (div_done) begin
            // a rest stays silent even when the divisor is zero
            phase_step <= (note_rd[mtg_pkg::NOTE_WORD_W-1 -: mtg_pkg::FREQ_W] == '0)
                          ? '0 : div_quo;
            pending    <= pending - 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // note table: write on load beats, registered read at the current note
  always_ff @(posedge clk) begin
    if (item_fire && item.op == mtg_pkg::OP_LOAD) begin
      note_mem[slot_wrap[item.entry_index]] <= {item.entry_freq, item.entry_duration};
    end
    note_rd <= note_mem[current_note];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_fire && item.op == mtg_pkg::OP_SAMPLE) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && item.op == mtg_pkg::OP_SAMPLE) begin
      result.sample <= (phase_step != '0)
        ? mtg_pkg::sine_value(phase_accum[mtg_pkg::PHASE_W-1 -: mtg_pkg::SINE_IDX_W])
        : '0;
      result.note_index <= mtg_pkg::NOTE_INDEX_W'(current_note);
    end
  end

  // next note index: (current_note + 1) mod length
  mtg_serial_div #(
    .DVD_W (CNT_W),
    .DVS_W (CNT_W),
    .Q_W   (1)
  ) u_note_wrap (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (CNT_W'(current_note) + CNT_W'(1)),
    .divisor   (note_len),
    .done      (mod_done),
    .quotient  (),
    .remainder (mod_rem)
  );

  // phase increment: (freq << 32) / sample_rate, low 32 bits
  mtg_serial_div #(
    .DVD_W (DIV_DVD_W),
    .DVS_W (mtg_pkg::RATE_W),
    .Q_W   (mtg_pkg::PHASE_W)
  ) u_step_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  ({note_rd[mtg_pkg::NOTE_WORD_W-1 -: mtg_pkg::FREQ_W],
                 {mtg_pkg::PHASE_W{1'b0}}}),
    .divisor   (sample_rate),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // assertions
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != mtg_pkg::ST_IDLE) |-> item_stall)
    else $error("input not stalled while sequencer busy");

  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    (state == mtg_pkg::ST_READ) |=> (state == mtg_pkg::ST_LOAD))
    else $error("table read not followed by load");

  a_phase_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == mtg_pkg::ST_IDLE && !item_fire) |=>
      ($stable(phase_accum) && $stable(phase_step)))
    else $error("phase state changed while idle");

  a_div_done_rem: assert property (@(posedge clk) disable iff (rst)
    (div_done && sample_rate != '0) |-> (div_rem < sample_rate))
    else $error("divider remainder out of range");

endmodule
`default_nettype wire
